// ----- hw/rtl/record_key_merge_sort_defines.svh -----
// ============================================================================
// record_key_merge_sort_defines.svh
// Assertion macros shared by the checker files of the merge sort block.
// ============================================================================
`ifndef RECORD_KEY_MERGE_SORT_DEFINES_SVH
`define RECORD_KEY_MERGE_SORT_DEFINES_SVH

// Check a property on the rising clock, suspended while reset is asserted.
`define RKMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock, including during reset.
`define RKMS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/rkms_pkg.sv -----
// ============================================================================
// rkms_pkg
// Shared widths, the ping-pong buffer entry layout and the memory request
// bundle passed from the sequencer to the buffer datapath.
// ============================================================================
package rkms_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int KEY_W       = 32;
    localparam int TAG_W       = 16;
    localparam int ENT_W       = KEY_W + TAG_W;

    typedef logic [ENT_W-1:0] entry_t;

    typedef struct packed {
        logic              we;
        logic              wsel;
        logic [IDX_W-1:0]  waddr;
        entry_t            wdata;
        logic              rsel;
        logic [IDX_W-1:0]  raddr_a;
        logic [IDX_W-1:0]  raddr_b;
    } mem_req_t;

    function automatic logic signed [KEY_W-1:0] entry_key(input entry_t e);
        entry_key = $signed(e[ENT_W-1 -: KEY_W]);
    endfunction

    function automatic logic [TAG_W-1:0] entry_tag(input entry_t e);
        entry_tag = e[TAG_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/rkms_ram.sv -----
// ============================================================================
// rkms_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ============================================================================
module rkms_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- hw/rtl/rkms_seq.sv -----
// ============================================================================
// rkms_seq
// Sequencer: loads records, runs bottom-up merge passes between the two
// buffers (read both run heads, then write the winner, per record), then
// streams the sorted run out.
module rkms_seq
    import rkms_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [KEY_W-1:0]  sort_key,
    input  logic [TAG_W-1:0]         record_tag,
    input  logic                     final_item,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [KEY_W-1:0]  sorted_key,
    output logic [TAG_W-1:0]         sorted_tag,
    output logic                     end_of_run,
    output logic                     overflowed,
    output mem_req_t                 req,
    input  entry_t                   rd_a,
    input  entry_t                   rd_b
);

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_MRD   = 6'b000100,
        ST_MWR   = 6'b001000,
        ST_EMRD  = 6'b010000,
        ST_EMOUT = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic               ovf_reg, ovf_next;
    logic [CNT_W-1:0]   w_reg, w_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   mid_reg, mid_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic               src_reg, src_next;
    logic               emld_reg, emld_next;
    logic               oval_reg, oval_next;
    entry_t             odata_reg, odata_next;
    logic               oend_reg, oend_next;
    logic               oovf_reg, oovf_next;

    logic [CNT_W:0]     sum_mid;
    logic [CNT_W:0]     sum_hi;
    logic [CNT_W:0]     w_dbl;
    logic [CNT_W-1:0]   k_inc;
    logic [CNT_W-1:0]   n_inc;
    logic               take_r;

    assign sum_mid = {1'b0, lo_reg} + {1'b0, w_reg};
    assign sum_hi  = {1'b0, lo_reg} + {w_reg, 1'b0};
    assign w_dbl   = {w_reg, 1'b0};
    assign k_inc   = k_reg + CNT_W'(1);
    assign n_inc   = (n_reg == CNT_W'(MAX_RECORDS)) ? n_reg : n_reg + CNT_W'(1);
    assign take_r  = (j_reg < hi_reg) &&
                     ((i_reg >= mid_reg) || (entry_key(rd_b) < entry_key(rd_a)));

    assign in_ready   = (state_reg == ST_LOAD);
    assign out_valid  = oval_reg;
    assign sorted_key = entry_key(odata_reg);
    assign sorted_tag = entry_tag(odata_reg);
    assign end_of_run = oend_reg;
    assign overflowed = oovf_reg;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        ovf_next   = ovf_reg;
        w_next     = w_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        src_next   = src_reg;
        emld_next  = 1'b0;
        oval_next  = oval_reg;
        odata_next = odata_reg;
        oend_next  = oend_reg;
        oovf_next  = oovf_reg;

        req         = '0;
        req.rsel    = src_reg;
        req.raddr_a = i_reg[IDX_W-1:0];
        req.raddr_b = j_reg[IDX_W-1:0];

        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    if (n_reg != CNT_W'(MAX_RECORDS))
                    begin
                        req.we    = 1'b1;
                        req.wsel  = 1'b0;
                        req.waddr = n_reg[IDX_W-1:0];
                        req.wdata = {sort_key, record_tag};
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    n_next = n_inc;
                    if (final_item)
                    begin
                        w_next   = CNT_W'(1);
                        lo_next  = '0;
                        k_next   = '0;
                        src_next = 1'b0;
                        state_next = (n_inc <= CNT_W'(1)) ? ST_EMRD : ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                mid_next = (sum_mid >= {1'b0, n_reg}) ? n_reg : sum_mid[CNT_W-1:0];
                hi_next  = (sum_hi >= {1'b0, n_reg}) ? n_reg : sum_hi[CNT_W-1:0];
                i_next   = lo_reg;
                j_next   = (sum_mid >= {1'b0, n_reg}) ? n_reg : sum_mid[CNT_W-1:0];
                k_next   = lo_reg;
                state_next = ST_MRD;
            end
            ST_MRD:
            begin
                state_next = ST_MWR;
            end
            ST_MWR:
            begin
                req.we    = 1'b1;
                req.wsel  = ~src_reg;
                req.waddr = k_reg[IDX_W-1:0];
                req.wdata = take_r ? rd_b : rd_a;
                if (take_r)
                begin
                    j_next = j_reg + CNT_W'(1);
                end
                else
                begin
                    i_next = i_reg + CNT_W'(1);
                end
                k_next = k_inc;
                if (k_inc == hi_reg)
                begin
                    if (sum_hi >= {1'b0, n_reg})
                    begin
                        w_next   = w_dbl[CNT_W-1:0];
                        src_next = ~src_reg;
                        lo_next  = '0;
                        if (w_dbl >= {1'b0, n_reg})
                        begin
                            k_next     = '0;
                            state_next = ST_EMRD;
                        end
                        else
                        begin
                            state_next = ST_SETUP;
                        end
                    end
                    else
                    begin
                        lo_next    = sum_hi[CNT_W-1:0];
                        state_next = ST_SETUP;
                    end
                end
                else
                begin
                    state_next = ST_MRD;
                end
            end
            ST_EMRD:
            begin
                req.raddr_a = k_reg[IDX_W-1:0];
                emld_next   = 1'b1;
                state_next  = ST_EMOUT;
            end
            ST_EMOUT:
            begin
                if (emld_reg)
                begin
                    oval_next  = 1'b1;
                    odata_next = rd_a;
                    oend_next  = (k_inc == n_reg);
                    oovf_next  = ovf_reg;
                end
                else if (out_ready)
                begin
                    oval_next = 1'b0;
                    if (oend_reg)
                    begin
                        n_next     = '0;
                        ovf_next   = 1'b0;
                        src_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_inc;
                        state_next = ST_EMRD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            n_reg     <= '0;
            ovf_reg   <= 1'b0;
            src_reg   <= 1'b0;
            emld_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            ovf_reg   <= ovf_next;
            src_reg   <= src_next;
            emld_reg  <= emld_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg     <= w_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        odata_reg <= odata_next;
        oend_reg  <= oend_next;
        oovf_reg  <= oovf_next;
    end

endmodule

// ----- hw/rtl/record_key_merge_sort.sv -----
// ============================================================================
// record_key_merge_sort
// Stable ascending merge sort of up to MAX_RECORDS key/tag records.
// ============================================================================
// Records load at one beat per cycle into buffer 0. The beat marked final
// starts a bottom-up merge: ceil(log2 n) passes ping-pong between two RAMs,
// each pass reading both run heads and then writing the winner for each
// record, after a setup step for each pair of runs. The sorted run then
// leaves one beat at a time: each record is read, registered and held
// until the sink is ready, before the next record is read. The input is
// not ready during sorting and emission. Beats beyond capacity are dropped
// and every output beat of that set carries overflowed.
// ============================================================================
module record_key_merge_sort
    import rkms_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [KEY_W-1:0]  sort_key,
    input  logic [TAG_W-1:0]         record_tag,
    input  logic                     final_item,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [KEY_W-1:0]  sorted_key,
    output logic [TAG_W-1:0]         sorted_tag,
    output logic                     end_of_run,
    output logic                     overflowed
);

    mem_req_t req;
    entry_t   buf0_a, buf0_b, buf1_a, buf1_b;
    entry_t   rd_a, rd_b;

    rkms_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sort_key   (sort_key),
        .record_tag (record_tag),
        .final_item (final_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sorted_key (sorted_key),
        .sorted_tag (sorted_tag),
        .end_of_run (end_of_run),
        .overflowed (overflowed),
        .req        (req),
        .rd_a       (rd_a),
        .rd_b       (rd_b)
    );

    rkms_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_RECORDS)
    ) u_buf0 (
        .clk     (clk),
        .we      (req.we & ~req.wsel),
        .waddr   (req.waddr),
        .wdata   (req.wdata),
        .raddr_a (req.raddr_a),
        .raddr_b (req.raddr_b),
        .rdata_a (buf0_a),
        .rdata_b (buf0_b)
    );

    rkms_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_RECORDS)
    ) u_buf1 (
        .clk     (clk),
        .we      (req.we & req.wsel),
        .waddr   (req.waddr),
        .wdata   (req.wdata),
        .raddr_a (req.raddr_a),
        .raddr_b (req.raddr_b),
        .rdata_a (buf1_a),
        .rdata_b (buf1_b)
    );

    assign rd_a = req.rsel ? buf1_a : buf0_a;
    assign rd_b = req.rsel ? buf1_b : buf0_b;

endmodule

// ----- hw/rtl/rkms_checker.sv -----
// ============================================================================
// rkms_checker
// Port-level checks: output ordering, flag consistency, beat hold and no input ready while a beat is pending.
// ============================================================================
`include "record_key_merge_sort_defines.svh"

module rkms_checker
    import rkms_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_ready,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [KEY_W-1:0]  sorted_key,
    input  logic [TAG_W-1:0]         sorted_tag,
    input  logic                     end_of_run,
    input  logic                     overflowed
);

    logic                     in_run_reg;
    logic signed [KEY_W-1:0]  last_key_reg;
    logic                     last_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            in_run_reg <= ~end_of_run;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            last_key_reg <= sorted_key;
            last_ovf_reg <= overflowed;
        end
    end

    `RKMS_ASSERT(a_out_hold,
        out_valid && !out_ready |=> out_valid && $stable(sorted_key) && $stable(sorted_tag),
        "stalled output beat changed")
    `RKMS_ASSERT(a_no_load_while_out,
        out_valid |-> !in_ready,
        "input ready while a sorted beat is pending")
    `RKMS_ASSERT(a_ascending,
        out_valid && in_run_reg |-> sorted_key >= last_key_reg,
        "sorted keys out of order")
    `RKMS_ASSERT(a_ovf_steady,
        out_valid && in_run_reg |-> overflowed == last_ovf_reg,
        "overflow flag changed within a run")

endmodule

bind record_key_merge_sort rkms_checker u_rkms_checker (.*);
